FILE: hdl/fia_pkg.sv
// Shared constants and types for the Fisher information accumulator.
// Used by fia_ctrl, fia_datapath and fisher_information_accumulator_top.
`default_nettype none

package fia_pkg;

    localparam int MAX_PARAMS = 8;
    localparam int ACC_WIDTH  = 48;
    localparam int GRAD_W     = 16;
    localparam int WEIGHT_W   = 17;
    localparam int CFG_W      = 4;
    localparam int VALUE_W    = 48;
    localparam int POS_W      = 3;
    localparam int IDX_W      = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
    localparam int FRAC_SHIFT = 16;
    localparam int WG_W       = WEIGHT_W + 1 + GRAD_W;
    localparam int PROD_W     = WG_W + GRAD_W;
    localparam int SUM_W      = ACC_WIDTH + 1;
    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(MAX_PARAMS);

    typedef logic signed [GRAD_W-1:0] t_grad;
    typedef logic [MAX_PARAMS-1:0][GRAD_W-1:0] t_grad_vec;
    typedef logic [IDX_W-1:0] t_idx;

    typedef struct packed {
        logic load;
        logic issue;
        t_idx issue_row;
        t_idx max_idx;
        logic emit;
        t_idx emit_row;
        t_idx emit_col;
        logic emit_last;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

FILE: hdl/fia_ctrl.sv
// Controller: sample handshake, dimension register, row issue and matrix emission.
// Depends on fia_pkg; drives fia_datapath through t_cmd.
`default_nettype none

module fia_ctrl (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic                       i_last_sample,
    input  wire logic                       i_cfg_we,
    input  wire logic [fia_pkg::CFG_W-1:0]  i_cfg_data,
    input  wire fia_pkg::t_status           i_status,
    output fia_pkg::t_cmd                   o_cmd
);
    import fia_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ACC   = 4'b0010,
        S_DRAIN = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    logic [CFG_W-1:0] r_cfg;
    t_idx             r_row, n_row;
    t_idx             r_er, n_er;
    t_idx             r_ec, n_ec;
    logic             r_last, n_last;
    logic             r_drain, n_drain;
    t_idx             max_idx;
    logic             accept;

    always_comb begin
        if (r_cfg == '0) begin
            max_idx = '0;
        end else if (r_cfg > CFG_W'(MAX_PARAMS)) begin
            max_idx = IDX_W'(MAX_PARAMS - 1);
        end else begin
            max_idx = IDX_W'(r_cfg - CFG_W'(1));
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid & o_ready;

    always_comb begin
        n_state = r_state;
        n_row   = r_row;
        n_er    = r_er;
        n_ec    = r_ec;
        n_last  = r_last;
        n_drain = r_drain;
        o_cmd   = '0;
        o_cmd.max_idx   = max_idx;
        o_cmd.load      = accept;
        o_cmd.issue_row = r_row;
        o_cmd.emit_row  = r_er;
        o_cmd.emit_col  = r_ec;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_row   = '0;
                    n_last  = i_last_sample;
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.issue = 1'b1;
                if (r_row == max_idx) begin
                    n_drain = 1'b0;
                    n_state = r_last ? S_DRAIN : S_IDLE;
                end else begin
                    n_row = r_row + IDX_W'(1);
                end
            end
            S_DRAIN: begin
                if (r_drain) begin
                    n_er    = '0;
                    n_ec    = '0;
                    n_state = S_EMIT;
                end else begin
                    n_drain = 1'b1;
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (r_ec == max_idx) begin
                        n_ec = '0;
                        if (r_er == max_idx) begin
                            o_cmd.emit_last = 1'b1;
                            o_cmd.clear     = 1'b1;
                            n_state         = S_IDLE;
                        end else begin
                            n_er = r_er + IDX_W'(1);
                        end
                    end else begin
                        n_ec = r_ec + IDX_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cfg   <= CFG_RESET;
            r_row   <= '0;
            r_er    <= '0;
            r_ec    <= '0;
            r_last  <= 1'b0;
            r_drain <= 1'b0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_er    <= n_er;
            r_ec    <= n_ec;
            r_last  <= n_last;
            r_drain <= n_drain;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/fia_datapath.sv
// Datapath: sample registers, weight and outer-product multiplier row,
// saturating row update of the accumulator matrix and the result register.
// Depends on fia_pkg; commanded by fia_ctrl through t_cmd.
`default_nettype none

module fia_datapath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire fia_pkg::t_cmd                 i_cmd,
    output fia_pkg::t_status                   o_status,
    input  wire fia_pkg::t_grad_vec            i_grad,
    input  wire logic [fia_pkg::WEIGHT_W-1:0]  i_weight,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [fia_pkg::POS_W-1:0]          o_row,
    output logic [fia_pkg::POS_W-1:0]          o_col,
    output logic signed [fia_pkg::VALUE_W-1:0] o_value,
    output logic                               o_last_entry
);
    import fia_pkg::*;

    t_grad                       r_grad [MAX_PARAMS];
    logic [WEIGHT_W-1:0]         r_weight;
    logic                        r_a_vld;
    t_idx                        r_a_row;
    logic signed [WG_W-1:0]      r_wg;
    logic                        r_b_vld;
    t_idx                        r_b_row;
    logic signed [PROD_W-1:0]    r_prod [MAX_PARAMS];
    logic [MAX_PARAMS-1:0][ACC_WIDTH-1:0] r_acc [MAX_PARAMS];
    logic [MAX_PARAMS-1:0]       r_row_vld;

    logic signed [WG_W-1:0]      wg_next;
    logic signed [PROD_W-1:0]    prod_next [MAX_PARAMS];
    t_idx                        rd_row;
    logic signed [ACC_WIDTH-1:0] rd_acc [MAX_PARAMS];
    logic signed [ACC_WIDTH-1:0] upd_acc [MAX_PARAMS];
    logic signed [PROD_W-1:0]    term [MAX_PARAMS];
    logic signed [SUM_W-1:0]     sum [MAX_PARAMS];

    assign o_status.out_free = !o_valid || i_ready;

    assign wg_next = $signed({1'b0, r_weight}) * r_grad[i_cmd.issue_row];

    always_comb begin
        for (int c = 0; c < MAX_PARAMS; c++) begin
            prod_next[c] = r_wg * r_grad[c];
        end
    end

    assign rd_row = i_cmd.emit ? i_cmd.emit_row : r_b_row;

    always_comb begin
        for (int c = 0; c < MAX_PARAMS; c++) begin
            rd_acc[c] = r_row_vld[rd_row] ? r_acc[rd_row][c] : '0;
            term[c]   = r_prod[c] >>> FRAC_SHIFT;
            sum[c]    = SUM_W'(rd_acc[c]) + SUM_W'(term[c]);
            if (sum[c][SUM_W-1] != sum[c][SUM_W-2]) begin
                upd_acc[c] = sum[c][SUM_W-1] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                                             : {1'b0, {(ACC_WIDTH-1){1'b1}}};
            end else begin
                upd_acc[c] = sum[c][ACC_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int k = 0; k < MAX_PARAMS; k++) begin
                r_grad[k] <= i_grad[k];
            end
            r_weight <= i_weight;
        end
        r_a_row <= i_cmd.issue_row;
        r_wg    <= wg_next;
        r_b_row <= r_a_row;
        for (int c = 0; c < MAX_PARAMS; c++) begin
            r_prod[c] <= prod_next[c];
        end
        if (r_b_vld) begin
            for (int c = 0; c < MAX_PARAMS; c++) begin
                if (IDX_W'(c) <= i_cmd.max_idx) begin
                    r_acc[r_b_row][c] <= upd_acc[c];
                end else if (!r_row_vld[r_b_row]) begin
                    r_acc[r_b_row][c] <= '0;
                end
            end
        end
        if (i_cmd.emit) begin
            o_row        <= POS_W'(i_cmd.emit_row);
            o_col        <= POS_W'(i_cmd.emit_col);
            o_value      <= VALUE_W'(rd_acc[i_cmd.emit_col]);
            o_last_entry <= i_cmd.emit_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld   <= 1'b0;
            r_b_vld   <= 1'b0;
            r_row_vld <= '0;
            o_valid   <= 1'b0;
        end else begin
            r_a_vld <= i_cmd.issue;
            r_b_vld <= r_a_vld;
            if (i_cmd.clear) begin
                r_row_vld <= '0;
            end else if (r_b_vld) begin
                r_row_vld[r_b_row] <= 1'b1;
            end
            if (i_cmd.emit) begin
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/fisher_information_accumulator_top.sv
// Top level of the Fisher information accumulator: ports, fia_ctrl and fia_datapath.
// Depends on fia_pkg, fia_ctrl and fia_datapath.
//
// Usage:
//   Input channel (i_valid/o_ready) takes one sample per beat: eight signed Q4.12
//   gradient elements, an unsigned Q1.16 weight and a last-sample flag.
//   i_cfg_we/i_cfg_data write the matrix dimension n (0 acts as 1, above 8 as 8).
//   Each sample issues one matrix row per cycle into a three-stage row
//   pipeline (weight multiply, row of eight multipliers, saturating update),
//   so a sample occupies the input for one accept plus n row issues.
//   On a last sample, a drain state follows, then the n*n entries leave on
//   the output channel (o_valid/i_ready) in row-major order, one beat per
//   cycle while the receiver takes them; o_last_entry marks the final one.
//   The accumulators clear as the final entry is loaded, and the next sample
//   is taken while that entry still waits in the output register.
//   A stalled receiver holds emission; no sample is taken during emission.
//   Reset (synchronous, active low) zeroes the matrix, sets n to 8 and
//   empties the output register.
`default_nettype none

module fisher_information_accumulator_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic signed [15:0]            i_grad_0,
    input  wire logic signed [15:0]            i_grad_1,
    input  wire logic signed [15:0]            i_grad_2,
    input  wire logic signed [15:0]            i_grad_3,
    input  wire logic signed [15:0]            i_grad_4,
    input  wire logic signed [15:0]            i_grad_5,
    input  wire logic signed [15:0]            i_grad_6,
    input  wire logic signed [15:0]            i_grad_7,
    input  wire logic [fia_pkg::WEIGHT_W-1:0]  i_weight,
    input  wire logic                          i_last_sample,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [fia_pkg::POS_W-1:0]          o_row,
    output logic [fia_pkg::POS_W-1:0]          o_col,
    output logic signed [fia_pkg::VALUE_W-1:0] o_value,
    output logic                               o_last_entry,
    input  wire logic                          i_cfg_we,
    input  wire logic [fia_pkg::CFG_W-1:0]     i_cfg_data
);
    import fia_pkg::*;

    t_cmd      cmd;
    t_status   status;
    t_grad_vec grad;

    assign grad[0] = i_grad_0;
    assign grad[1] = i_grad_1;
    assign grad[2] = i_grad_2;
    assign grad[3] = i_grad_3;
    assign grad[4] = i_grad_4;
    assign grad[5] = i_grad_5;
    assign grad[6] = i_grad_6;
    assign grad[7] = i_grad_7;

    fia_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_last_sample (i_last_sample),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_status      (status),
        .o_cmd         (cmd)
    );

    fia_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_grad       (grad),
        .i_weight     (i_weight),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_row        (o_row),
        .o_col        (o_col),
        .o_value      (o_value),
        .o_last_entry (o_last_entry)
    );

    a_last_on_diag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_entry |-> o_row == o_col)
        else $error("final entry off the diagonal");

    a_no_accept_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> !o_ready)
        else $error("sample taken during emission");

    a_clear_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.clear |-> cmd.emit && cmd.emit_last)
        else $error("clear without final entry");

    a_emit_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> cmd.emit_row <= cmd.max_idx && cmd.emit_col <= cmd.max_idx)
        else $error("entry outside dimension");

    a_issue_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.issue |-> !o_ready)
        else $error("sample taken during row issue");

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// Testbench for fisher_information_accumulator_top: directed, large-term and random batches.
// The monitor checks every entry against an in-bench Fisher matrix predictor fed by the driver.
// Depends on fia_pkg and fisher_information_accumulator_top.
`default_nettype none

module testbench;
    import fia_pkg::*;

    localparam int     LIMIT_CYCLES   = 1_500_000;
    localparam int     SETTLE_CYCLES  = 16;
    localparam int     RX_HOLD_CYCLES = 300;
    localparam int     SAT_SAMPLES    = 4;
    localparam int     RAND_PHASES    = 6;
    localparam int     PHASE_SAMPLES  = 25;
    localparam longint ACC_HI         = (longint'(1) <<< (ACC_WIDTH - 1)) - 1;
    localparam longint ACC_LO         = -ACC_HI - 1;

    typedef struct packed {
        t_grad_vec           grad;
        logic [WEIGHT_W-1:0] weight;
        logic                last;
    } t_sample;

    typedef struct packed {
        logic [POS_W-1:0]   row;
        logic [POS_W-1:0]   col;
        logic [VALUE_W-1:0] value;
        logic               last;
    } t_entry;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_valid       = 1'b0;
    logic                i_ready       = 1'b0;
    t_grad_vec           grad_bus      = '0;
    logic [WEIGHT_W-1:0] i_weight      = '0;
    logic                i_last_sample = 1'b0;
    logic                i_cfg_we      = 1'b0;
    logic [CFG_W-1:0]    i_cfg_data    = '0;
    logic                o_ready;
    logic                o_valid;
    logic [POS_W-1:0]    o_row;
    logic [POS_W-1:0]    o_col;
    logic [VALUE_W-1:0]  o_value;
    logic                o_last_entry;

    t_sample                     sample_q[$];
    t_entry                      entry_due_q[$];
    t_sample                     tx_item;
    logic signed [ACC_WIDTH-1:0] fim_acc [MAX_PARAMS*MAX_PARAMS];
    logic [CFG_W-1:0]            dim_cfg     = CFG_RESET;
    int                          sent_count  = 0;
    int                          taken_count = 0;
    int                          beat_count  = 0;
    int                          holds_done  = 0;
    int                          err_count   = 0;
    int                          tx_wait     = 0;
    int                          rx_wait     = 0;
    int                          rx_hold     = 0;
    int                          cycle_count = 0;
    bit                          calm        = 1'b0;

    fisher_information_accumulator_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_grad_0     (grad_bus[0]),
        .i_grad_1     (grad_bus[1]),
        .i_grad_2     (grad_bus[2]),
        .i_grad_3     (grad_bus[3]),
        .i_grad_4     (grad_bus[4]),
        .i_grad_5     (grad_bus[5]),
        .i_grad_6     (grad_bus[6]),
        .i_grad_7     (grad_bus[7]),
        .i_weight     (i_weight),
        .i_last_sample(i_last_sample),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_row        (o_row),
        .o_col        (o_col),
        .o_value      (o_value),
        .o_last_entry (o_last_entry),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic int draw_gap();
        return calm ? 0 : $urandom_range(0, 12);
    endfunction

    function automatic void fim_absorb(input t_sample s);
        int     n;
        int     r;
        int     c;
        int     k;
        longint gr;
        longint gc;
        longint w;
        longint term;
        longint sum;
        t_entry e;
        n = (dim_cfg == 0) ? 1 : (dim_cfg > MAX_PARAMS) ? MAX_PARAMS : int'(dim_cfg);
        w = longint'(s.weight);
        for (r = 0; r < n; r++) begin
            for (c = 0; c < n; c++) begin
                k    = r * MAX_PARAMS + c;
                gr   = longint'($signed(s.grad[r]));
                gc   = longint'($signed(s.grad[c]));
                term = (gr * gc * w) >>> FRAC_SHIFT;
                sum  = longint'(fim_acc[k]) + term;
                if (sum > ACC_HI) sum = ACC_HI;
                if (sum < ACC_LO) sum = ACC_LO;
                fim_acc[k] = sum[ACC_WIDTH-1:0];
            end
        end
        if (s.last) begin
            for (r = 0; r < n; r++) begin
                for (c = 0; c < n; c++) begin
                    e.row   = r[POS_W-1:0];
                    e.col   = c[POS_W-1:0];
                    e.value = fim_acc[r * MAX_PARAMS + c][VALUE_W-1:0];
                    e.last  = (r == n - 1) && (c == n - 1);
                    entry_due_q.push_back(e);
                end
            end
            foreach (fim_acc[i]) fim_acc[i] = '0;
        end
    endfunction

    task automatic log_mismatch(input string msg);
        $display("MISMATCH: %s", msg);
        err_count++;
    endtask

    task automatic check_entry();
        t_entry want;
        if (entry_due_q.size() == 0) begin
            log_mismatch($sformatf("entry (%0d,%0d) value %h with nothing due",
                                   o_row, o_col, o_value));
        end else begin
            want = entry_due_q.pop_front();
            if (o_row !== want.row)
                log_mismatch($sformatf("row: got %0d exp %0d", o_row, want.row));
            if (o_col !== want.col)
                log_mismatch($sformatf("col at row %0d: got %0d exp %0d",
                                       want.row, o_col, want.col));
            if (o_value !== want.value)
                log_mismatch($sformatf("value at (%0d,%0d): got %h exp %h",
                                       want.row, want.col, o_value, want.value));
            if (o_last_entry !== want.last)
                log_mismatch($sformatf("last_entry at (%0d,%0d): got %b exp %b",
                                       want.row, want.col, o_last_entry, want.last));
        end
    endtask

    // sample driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            tx_wait = 0;
            foreach (fim_acc[i]) fim_acc[i] = '0;
        end else begin
            if (i_valid && o_ready) begin
                fim_absorb(tx_item);
                taken_count++;
            end
            if (!i_valid || o_ready) begin
                if (tx_wait > 0) begin
                    tx_wait--;
                    i_valid <= 1'b0;
                end else if (sample_q.size() > 0) begin
                    tx_item = sample_q.pop_front();
                    grad_bus      <= tx_item.grad;
                    i_weight      <= tx_item.weight;
                    i_last_sample <= tx_item.last;
                    i_valid       <= 1'b1;
                    tx_wait = draw_gap();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // entry monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            rx_wait = 0;
            rx_hold = 0;
        end else begin
            if (o_valid && i_ready) begin
                check_entry();
                beat_count++;
                rx_wait = draw_gap();
                if (holds_done < 2 && beat_count >= 200 * (holds_done + 1)
                        && sample_q.size() > 0) begin
                    rx_hold = RX_HOLD_CYCLES;
                    holds_done++;
                end
            end
            if (rx_hold > 0) begin
                rx_hold--;
                i_ready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic t_sample uniform_sample(input logic [GRAD_W-1:0] g,
                                               input logic [WEIGHT_W-1:0] w,
                                               input logic last);
        t_sample s;
        int      k;
        for (k = 0; k < MAX_PARAMS; k++) s.grad[k] = g;
        s.weight = w;
        s.last   = last;
        return s;
    endfunction

    function automatic t_sample random_sample(input logic last);
        t_sample s;
        int      k;
        for (k = 0; k < MAX_PARAMS; k++) begin
            case ($urandom_range(0, 3))
                0: begin
                    case ($urandom_range(0, 3))
                        0: s.grad[k] = 16'h7FFF;
                        1: s.grad[k] = 16'h8000;
                        2: s.grad[k] = 16'h0000;
                        default: s.grad[k] = 16'hFFFF;
                    endcase
                end
                1: s.grad[k] = 16'($urandom_range(0, 1023) - 512);
                default: s.grad[k] = 16'($urandom);
            endcase
        end
        case ($urandom_range(0, 3))
            0: s.weight = 17'd65536;
            1: s.weight = $urandom_range(0, 1) ? 17'd0 : 17'd131071;
            default: s.weight = 17'($urandom_range(0, 131071));
        endcase
        s.last = last;
        return s;
    endfunction

    task automatic queue_sample(input t_sample s);
        sample_q.push_back(s);
        sent_count++;
    endtask

    task automatic wait_drained();
        while (taken_count != sent_count || entry_due_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_dim(input logic [CFG_W-1:0] v);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        dim_cfg = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        t_sample s;
        int      i;
        int      p;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes at the reset dimension
        queue_sample(uniform_sample(16'h0000, 17'd65536, 1'b0));
        queue_sample(uniform_sample(16'h7FFF, 17'd65536, 1'b0));
        queue_sample(uniform_sample(16'h8000, 17'd131071, 1'b0));
        s = uniform_sample(16'h7FFF, 17'd1, 1'b0);
        for (i = 1; i < MAX_PARAMS; i += 2) s.grad[i] = 16'h8000;
        queue_sample(s);
        queue_sample(uniform_sample(16'hFFFF, 17'd65535, 1'b0));
        queue_sample(uniform_sample(16'h0001, 17'd131071, 1'b0));
        s = random_sample(1'b1);
        s.weight = '0;
        queue_sample(s);

        // clamp an oversized dimension
        write_dim(4'd15);
        queue_sample(uniform_sample(16'h7FFF, 17'd65536, 1'b0));
        queue_sample(random_sample(1'b1));

        // dimension zero acts as one
        write_dim(4'd0);
        queue_sample(uniform_sample(16'h8000, 17'd131071, 1'b0));
        queue_sample(uniform_sample(16'h7FFF, 17'd65536, 1'b1));

        // shrink mid-batch, then confirm the hidden entries were cleared
        write_dim(4'd8);
        queue_sample(uniform_sample(16'h8000, 17'd65536, 1'b0));
        queue_sample(random_sample(1'b0));
        write_dim(4'd2);
        queue_sample(random_sample(1'b1));
        write_dim(4'd8);
        queue_sample(uniform_sample(16'h0000, 17'd0, 1'b1));

        write_dim(4'd1);
        queue_sample(random_sample(1'b0));
        queue_sample(random_sample(1'b1));
        write_dim(4'd9);
        queue_sample(random_sample(1'b1));

        // grow mid-batch
        write_dim(4'd3);
        s = uniform_sample(16'h8000, 17'd131071, 1'b0);
        s.grad[1] = 16'h7FFF;
        queue_sample(s);
        queue_sample(random_sample(1'b0));
        write_dim(4'd5);
        queue_sample(random_sample(1'b1));
        write_dim(4'd6);
        queue_sample(random_sample(1'b0));
        queue_sample(random_sample(1'b1));

        // accumulate the largest terms of both signs back to back
        write_dim(4'd2);
        calm = 1'b1;
        for (i = 0; i < SAT_SAMPLES; i++) begin
            s = uniform_sample(16'h8000, 17'd131071, i == SAT_SAMPLES - 1);
            s.grad[1] = 16'h7FFF;
            queue_sample(s);
        end
        wait_drained();
        calm = 1'b0;

        for (p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0: write_dim(4'd8);
                1: write_dim(4'd1);
                default: write_dim(CFG_W'($urandom_range(0, 15)));
            endcase
            calm = (p == 3);
            for (i = 0; i < PHASE_SAMPLES; i++)
                queue_sample(random_sample(($urandom_range(0, 4) == 0)
                                           || (p == RAND_PHASES - 1 && i == PHASE_SAMPLES - 1)));
        end

        wait_drained();
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire
